>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed (same cycle)");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed (next cycle)");

`endif

>>> rtl/core/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared widths, codes, step tables and helpers of the thick line rasterizer.
// ----------------------------------------------------------------------------
package tlr_pkg;

    localparam int COORD_W = 6;
    localparam int HALF_W  = 3;
    localparam int LEN_W   = 4;
    localparam int DEC_W   = 12;
    localparam int CNT_W   = 6;
    localparam int IDX_W   = 2;
    localparam int OCT_W   = 3;

    localparam logic [COORD_W-1:0] COORD_MAX = 6'd63;
    localparam logic [CNT_W-1:0]   SPAN_LAST = 6'd63;

    localparam logic [IDX_W-1:0] REG_X_LIMIT = 2'd0;
    localparam logic [IDX_W-1:0] REG_Y_LIMIT = 2'd1;

    // octants, counted from +y clockwise
    localparam logic [OCT_W-1:0] OCT_NNE = 3'd0;
    localparam logic [OCT_W-1:0] OCT_ENE = 3'd1;
    localparam logic [OCT_W-1:0] OCT_ESE = 3'd2;
    localparam logic [OCT_W-1:0] OCT_SSE = 3'd3;
    localparam logic [OCT_W-1:0] OCT_SSW = 3'd4;
    localparam logic [OCT_W-1:0] OCT_WSW = 3'd5;
    localparam logic [OCT_W-1:0] OCT_WNW = 3'd6;
    localparam logic [OCT_W-1:0] OCT_NNW = 3'd7;

    typedef struct packed {
        logic load;
        logic init;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
    } step_t;

    localparam logic signed [1:0] D_POS  = 2'sb01;
    localparam logic signed [1:0] D_ZERO = 2'sb00;
    localparam logic signed [1:0] D_NEG  = 2'sb11;

    function automatic step_t under_step(input logic [OCT_W-1:0] oct);
        step_t s;
        case (oct)
            OCT_NNE: s = '{dx: D_POS,  dy: D_POS};
            OCT_ENE: s = '{dx: D_POS,  dy: D_ZERO};
            OCT_ESE: s = '{dx: D_POS,  dy: D_NEG};
            OCT_SSE: s = '{dx: D_ZERO, dy: D_NEG};
            OCT_SSW: s = '{dx: D_NEG,  dy: D_NEG};
            OCT_WSW: s = '{dx: D_NEG,  dy: D_ZERO};
            OCT_WNW: s = '{dx: D_NEG,  dy: D_POS};
            default: s = '{dx: D_ZERO, dy: D_POS};
        endcase
        return s;
    endfunction

    function automatic step_t up_step(input logic [OCT_W-1:0] oct);
        step_t s;
        case (oct)
            OCT_NNE: s = '{dx: D_ZERO, dy: D_POS};
            OCT_ENE: s = '{dx: D_POS,  dy: D_POS};
            OCT_ESE: s = '{dx: D_POS,  dy: D_ZERO};
            OCT_SSE: s = '{dx: D_POS,  dy: D_NEG};
            OCT_SSW: s = '{dx: D_ZERO, dy: D_NEG};
            OCT_WSW: s = '{dx: D_NEG,  dy: D_NEG};
            OCT_WNW: s = '{dx: D_NEG,  dy: D_ZERO};
            default: s = '{dx: D_NEG,  dy: D_POS};
        endcase
        return s;
    endfunction

    function automatic logic is_vertical(input logic [OCT_W-1:0] oct);
        return (oct == OCT_ENE) || (oct == OCT_ESE) || (oct == OCT_WSW) || (oct == OCT_WNW);
    endfunction

    // coef in -2..2, done with shifts and negation
    function automatic logic signed [DEC_W-1:0] scale(input logic signed [2:0] coef,
                                                      input logic signed [DEC_W-1:0] v);
        logic signed [DEC_W-1:0] r;
        case (coef)
            3'sb001: r = v;
            3'sb010: r = v <<< 1;
            3'sb111: r = -v;
            3'sb110: r = -(v <<< 1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/tlr_ctrl.sv
// ----------------------------------------------------------------------------
// tlr_ctrl
// Sequencer: takes a line command, runs setup, then walks one span per beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output tlr_pkg::dp_cmd_t    cmd,
    input  tlr_pkg::dp_status_t status
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        cmd.load   = in_valid && in_ready;
        cmd.init   = (state_reg == ST_SETUP);
        cmd.emit   = (state_reg == ST_WALK) && (!out_valid_reg || out_ready);
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (cmd.emit && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_last_ends_walk, cmd.emit && status.last, state_reg == ST_IDLE)
    `ASSERT_NEXT(a_setup_to_walk, state_reg == ST_SETUP, state_reg == ST_WALK)
    `ASSERT_NEXT(a_emit_shows_beat, cmd.emit, out_valid)

endmodule

>>> rtl/core/tlr_dp.sv
// ----------------------------------------------------------------------------
// tlr_dp
// Datapath: clip limits, octant setup, midpoint walk and span clipping.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlr_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlr_pkg::dp_cmd_t              cmd,
    output tlr_pkg::dp_status_t           status,
    input  logic                          cfg_we,
    input  logic [tlr_pkg::IDX_W-1:0]     cfg_index,
    input  logic [tlr_pkg::COORD_W-1:0]   cfg_data,
    input  logic [tlr_pkg::COORD_W-1:0]   line_start_x,
    input  logic [tlr_pkg::COORD_W-1:0]   line_start_y,
    input  logic [tlr_pkg::COORD_W-1:0]   line_end_x,
    input  logic [tlr_pkg::COORD_W-1:0]   line_end_y,
    input  logic [tlr_pkg::HALF_W-1:0]    half_width,
    output logic [tlr_pkg::COORD_W-1:0]   span_x,
    output logic [tlr_pkg::COORD_W-1:0]   span_y,
    output logic                          span_vertical,
    output logic [tlr_pkg::LEN_W-1:0]     span_len,
    output logic                          last_span
);

    localparam int CW = tlr_pkg::COORD_W;
    localparam int DW = tlr_pkg::DEC_W;

    logic [CW-1:0]              x_limit_reg;
    logic [CW-1:0]              y_limit_reg;
    logic [CW-1:0]              cur_x_reg;
    logic [CW-1:0]              cur_y_reg;
    logic [CW-1:0]              target_x_reg;
    logic [CW-1:0]              target_y_reg;
    logic [tlr_pkg::HALF_W-1:0] stamp_reg;
    logic [tlr_pkg::OCT_W-1:0]  octant_reg;
    logic signed [DW-1:0]       decision_reg;
    logic signed [DW-1:0]       inc_under_reg;
    logic signed [DW-1:0]       inc_up_reg;
    logic [tlr_pkg::CNT_W-1:0]  count_reg;

    logic [CW-1:0]              span_x_reg;
    logic [CW-1:0]              span_y_reg;
    logic                       span_vertical_reg;
    logic [tlr_pkg::LEN_W-1:0]  span_len_reg;
    logic                       last_span_reg;

    // setup
    logic signed [DW-1:0]       dx;
    logic signed [DW-1:0]       dy;
    logic [CW-1:0]              adx;
    logic [CW-1:0]              ady;
    logic                       steep;
    logic [tlr_pkg::OCT_W-1:0]  octant_next;
    tlr_pkg::step_t             su_n;
    tlr_pkg::step_t             sp_n;
    logic signed [DW-1:0]       decision_init;
    logic signed [DW-1:0]       inc_under_init;
    logic signed [DW-1:0]       inc_up_init;

    // walk
    tlr_pkg::step_t             st;
    logic                       take_under;
    logic                       at_end;

    // span
    logic                       vert;
    logic [CW-1:0]              along;
    logic [CW-1:0]              across;
    logic [CW-1:0]              lim_along;
    logic [CW-1:0]              lim_across;
    logic [CW-1:0]              lo;
    logic [CW:0]                hi_sum;
    logic [CW-1:0]              hi;
    logic                       inside_span;
    logic [CW-1:0]              start;
    logic [CW-1:0]              len_w;
    logic [tlr_pkg::LEN_W-1:0]  len;

    always_comb
    begin
        dx = $signed({{(DW-CW){1'b0}}, target_x_reg}) - $signed({{(DW-CW){1'b0}}, cur_x_reg});
        dy = $signed({{(DW-CW){1'b0}}, target_y_reg}) - $signed({{(DW-CW){1'b0}}, cur_y_reg});
        adx = (cur_x_reg <= target_x_reg) ? (target_x_reg - cur_x_reg)
                                          : (cur_x_reg - target_x_reg);
        ady = (cur_y_reg <= target_y_reg) ? (target_y_reg - cur_y_reg)
                                          : (cur_y_reg - target_y_reg);
        steep = (ady > adx);
        if (cur_y_reg <= target_y_reg)
        begin
            if (cur_x_reg <= target_x_reg)
            begin
                octant_next = steep ? tlr_pkg::OCT_NNE : tlr_pkg::OCT_ENE;
            end
            else
            begin
                octant_next = steep ? tlr_pkg::OCT_NNW : tlr_pkg::OCT_WNW;
            end
        end
        else
        begin
            if (cur_x_reg <= target_x_reg)
            begin
                octant_next = steep ? tlr_pkg::OCT_SSE : tlr_pkg::OCT_ESE;
            end
            else
            begin
                octant_next = steep ? tlr_pkg::OCT_SSW : tlr_pkg::OCT_WSW;
            end
        end
        su_n = tlr_pkg::under_step(octant_next);
        sp_n = tlr_pkg::up_step(octant_next);
        decision_init  = tlr_pkg::scale({su_n.dx[1], su_n.dx} + {sp_n.dx[1], sp_n.dx}, dy)
                       - tlr_pkg::scale({su_n.dy[1], su_n.dy} + {sp_n.dy[1], sp_n.dy}, dx);
        inc_under_init = tlr_pkg::scale({su_n.dx, 1'b0}, dy) - tlr_pkg::scale({su_n.dy, 1'b0}, dx);
        inc_up_init    = tlr_pkg::scale({sp_n.dx, 1'b0}, dy) - tlr_pkg::scale({sp_n.dy, 1'b0}, dx);

        take_under  = (decision_reg <= 0);
        st          = take_under ? tlr_pkg::under_step(octant_reg)
                                 : tlr_pkg::up_step(octant_reg);
        at_end      = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);
        status.last = at_end || (count_reg == tlr_pkg::SPAN_LAST);

        vert       = tlr_pkg::is_vertical(octant_reg);
        along      = vert ? cur_y_reg : cur_x_reg;
        across     = vert ? cur_x_reg : cur_y_reg;
        lim_along  = vert ? y_limit_reg : x_limit_reg;
        lim_across = vert ? x_limit_reg : y_limit_reg;
        lo         = (along < CW'(stamp_reg)) ? '0 : (along - CW'(stamp_reg));
        hi_sum     = {1'b0, along} + (CW+1)'(stamp_reg);
        hi         = (hi_sum > {1'b0, lim_along}) ? lim_along : hi_sum[CW-1:0];
        inside_span = (across <= lim_across) && (lo <= hi);
        len_w      = hi - lo + 1'b1;
        len        = inside_span ? len_w[tlr_pkg::LEN_W-1:0] : '0;
        start      = inside_span ? lo : along;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= tlr_pkg::COORD_MAX;
            y_limit_reg <= tlr_pkg::COORD_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tlr_pkg::REG_X_LIMIT: x_limit_reg <= cfg_data;
                tlr_pkg::REG_Y_LIMIT: y_limit_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_x_reg    <= line_start_x;
            cur_y_reg    <= line_start_y;
            target_x_reg <= line_end_x;
            target_y_reg <= line_end_y;
            stamp_reg    <= half_width;
            count_reg    <= '0;
        end
        else if (cmd.init)
        begin
            octant_reg    <= octant_next;
            decision_reg  <= decision_init;
            inc_under_reg <= inc_under_init;
            inc_up_reg    <= inc_up_init;
        end
        else if (cmd.emit)
        begin
            span_x_reg        <= vert ? cur_x_reg : start;
            span_y_reg        <= vert ? start : cur_y_reg;
            span_vertical_reg <= vert;
            span_len_reg      <= len;
            last_span_reg     <= status.last;
            if (!status.last)
            begin
                cur_x_reg    <= cur_x_reg + {{(CW-2){st.dx[1]}}, st.dx};
                cur_y_reg    <= cur_y_reg + {{(CW-2){st.dy[1]}}, st.dy};
                decision_reg <= decision_reg + (take_under ? inc_under_reg : inc_up_reg);
                count_reg    <= count_reg + 1'b1;
            end
        end
    end

    assign span_x        = span_x_reg;
    assign span_y        = span_y_reg;
    assign span_vertical = span_vertical_reg;
    assign span_len      = span_len_reg;
    assign last_span     = last_span_reg;

    `ASSERT_NEXT(a_count_steps, cmd.emit && !status.last, count_reg == $past(count_reg) + 1'b1)
    `ASSERT_SAME(a_len_bounded, cmd.emit, len <= 4'd15 && (len == 4'd0 || start <= along))

endmodule

>>> rtl/core/thick_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// thick_line_rasterizer_core
// Eight-octant midpoint line walk emitting one clipped stamp span per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat carries a line command (start, end, half_width). Taken
//           only while no line is being walked.
//   out_* : one beat per walk pixel, in walk order; last_span marks the
//           span at the end point (or the 64th span).
//   cfg_* : cfg_index 0 writes x_limit, 1 writes y_limit, other indexes are
//           dropped. Always ready; write only while the core is idle.
// Timing:
//   The command is registered, the next cycle classifies the octant and
//   seeds the decision term, then the walk emits one span per cycle from
//   the output register while out_* is not stalled. A line of major length L
//   gives L+1 spans, at most 64. The next command is taken the cycle after
//   the last span is loaded into the output register.
// Reset:
//   Core idle, no beat pending, both limits 63.
// Stall:
//   With a span on out_* and out_ready low, the walk holds and the span stays.
// ----------------------------------------------------------------------------
module thick_line_rasterizer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tlr_pkg::COORD_W-1:0]   line_start_x,
    input  logic [tlr_pkg::COORD_W-1:0]   line_start_y,
    input  logic [tlr_pkg::COORD_W-1:0]   line_end_x,
    input  logic [tlr_pkg::COORD_W-1:0]   line_end_y,
    input  logic [tlr_pkg::HALF_W-1:0]    half_width,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tlr_pkg::COORD_W-1:0]   span_x,
    output logic [tlr_pkg::COORD_W-1:0]   span_y,
    output logic                          span_vertical,
    output logic [tlr_pkg::LEN_W-1:0]     span_len,
    output logic                          last_span,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tlr_pkg::IDX_W-1:0]     cfg_index,
    input  logic [tlr_pkg::COORD_W-1:0]   cfg_data
);

    tlr_pkg::dp_cmd_t    cmd;
    tlr_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    tlr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tlr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .line_start_x  (line_start_x),
        .line_start_y  (line_start_y),
        .line_end_x    (line_end_x),
        .line_end_y    (line_end_y),
        .half_width    (half_width),
        .span_x        (span_x),
        .span_y        (span_y),
        .span_vertical (span_vertical),
        .span_len      (span_len),
        .last_span     (last_span)
    );

endmodule
